// ===== rtl/core/start_stop_interval_histogram_assert.svh =====
// Assertion macros shared by the histogram core.
// SSIH_ASSERT_IMP: same-cycle implication. SSIH_ASSERT_NXT: next-cycle implication.
`ifndef START_STOP_INTERVAL_HISTOGRAM_ASSERT_SVH
`define START_STOP_INTERVAL_HISTOGRAM_ASSERT_SVH

`ifndef SYNTH
`define SSIH_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define SSIH_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define SSIH_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define SSIH_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif

`endif

// ===== rtl/core/ssih_pkg.sv =====
`default_nettype none
package ssih_pkg;

    localparam int NUM_BINS  = 100;
    localparam int TIME_BITS = 48;

    localparam int TS_W      = 48;
    localparam int TICK_W    = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
    localparam int BIN_W     = $clog2(NUM_BINS + 1);
    localparam int DEPTH     = NUM_BINS + 1;
    localparam int FRAC_BITS = 16;
    localparam int LIM_W     = BIN_W + FRAC_BITS;
    localparam int GAP_W     = 16;
    localparam int SCALE_W   = 24;
    localparam int OFFS_W    = 24;
    localparam int CH_W      = 2;
    localparam int RIDX_W    = 7;
    localparam int OBIN_W    = 7;
    localparam int CNT_W     = 32;
    localparam int PROD_W    = LIM_W + SCALE_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 1;

    typedef logic [TS_W-1:0]    t_ts;
    typedef logic [TICK_W-1:0]  t_tick;
    typedef logic [BIN_W-1:0]   t_bin;
    typedef logic [OBIN_W-1:0]  t_obin;
    typedef logic [RIDX_W-1:0]  t_ridx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [LIM_W-1:0]   t_mlo;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam t_sum BIN_LIMIT = t_sum'(NUM_BINS) << FRAC_BITS;
    localparam t_cnt CNT_MAX   = '1;

    localparam logic [GAP_W-1:0]   MIN_GAP_RST    = 16'd8;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RST  = 24'd1258;
    localparam logic [OFFS_W-1:0]  BIN_OFFSET_RST = 24'd252062;
    localparam logic [CH_W-1:0]    START_CH_RST   = 2'd1;
    localparam logic [CH_W-1:0]    STOP_CH_RST    = 2'd2;

    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP    = 3'd0,
        CFG_BIN_SCALE  = 3'd1,
        CFG_BIN_OFFSET = 3'd2,
        CFG_START_CH   = 3'd3,
        CFG_STOP_CH    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAP_W-1:0]   min_gap;
        logic [SCALE_W-1:0] bin_scale;
        logic [OFFS_W-1:0]  bin_offset;
        logic [CH_W-1:0]    start_ch;
        logic [CH_W-1:0]    stop_ch;
    } t_cfg;

    // event after the arm/interval stage
    typedef struct packed {
        t_op   op;
        logic  close;
        t_tick ticks;
        t_ridx ridx;
    } t_ivl_item;

    // request to the count bank
    typedef struct packed {
        t_op   op;
        logic  close;
        t_tick ticks;
        t_bin  addr;
        logic  oob;
    } t_bin_req;

    typedef struct packed {
        logic  ivl_valid;
        t_ts   ticks;
        t_obin bin;
        t_cnt  count;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/ssih_interval.sv =====
`default_nettype none
`include "start_stop_interval_histogram_assert.svh"
module ssih_interval (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  ssih_pkg::t_cfg            i_cfg,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire                       i_op,
    input  wire [ssih_pkg::CH_W-1:0]  i_ch,
    input  wire [ssih_pkg::TS_W-1:0]  i_ts,
    input  wire [ssih_pkg::RIDX_W-1:0] i_ridx,
    output logic                      o_valid,
    input  wire                       i_ready,
    output ssih_pkg::t_ivl_item       o_item
);

    logic                      r_v1;
    ssih_pkg::t_op             r_op;
    logic [ssih_pkg::CH_W-1:0] r_ch;
    ssih_pkg::t_ts             r_ts;
    ssih_pkg::t_ridx           r_ridx;
    logic                      r_armed;
    ssih_pkg::t_tick           r_start;

    ssih_pkg::t_tick ticks;
    logic            is_evt;
    logic            is_start;
    logic            is_stop;
    logic            close;
    logic            advance;

    always_comb begin
        ticks    = ssih_pkg::t_tick'(r_ts) - r_start;
        is_evt   = (r_op == ssih_pkg::OP_EVENT);
        is_start = is_evt && (r_ch == i_cfg.start_ch);
        // start wins when both codes match
        is_stop  = is_evt && !is_start && (r_ch == i_cfg.stop_ch) && r_armed;
        close    = is_stop && (64'(ticks) > 64'(i_cfg.min_gap));
        advance  = r_v1 && i_ready;
        o_ready  = !r_v1 || i_ready;
        o_valid  = r_v1;
        o_item.op    = r_op;
        o_item.close = close;
        o_item.ticks = ticks;
        o_item.ridx  = r_ridx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op   <= ssih_pkg::t_op'(i_op);
            r_ch   <= i_ch;
            r_ts   <= i_ts;
            r_ridx <= i_ridx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_start <= '0;
        end else if (advance) begin
            if (is_start) begin
                r_armed <= 1'b1;
                r_start <= ssih_pkg::t_tick'(r_ts);
            end else if (close) begin
                r_armed <= 1'b0;
            end
        end
    end

    `SSIH_ASSERT_NXT(a_close_disarms, i_clk, i_rst_n, advance && close, !r_armed, "armed after close")

endmodule
`default_nettype wire

// ===== rtl/core/ssih_binner.sv =====
`default_nettype none
module ssih_binner (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ssih_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  ssih_pkg::t_ivl_item i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output ssih_pkg::t_bin_req  o_req
);

    logic                r_v2;
    ssih_pkg::t_ivl_item r_it2;
    logic                r_v3;
    ssih_pkg::t_ivl_item r_it3;
    ssih_pkg::t_prod     r_prod;
    logic                r_hi;

    logic            rdy2;
    logic            rdy3;
    ssih_pkg::t_prod n_prod;
    logic            n_hi;
    ssih_pkg::t_sum  sum;
    logic            ovf;
    logic            oob;
    ssih_pkg::t_bin  bin;

    always_comb begin
        rdy3    = !r_v3 || i_ready;
        rdy2    = !r_v2 || rdy3;
        o_ready = rdy2;
        o_valid = r_v3;

        // ticks at or past 2^LIM_W overflow whenever scale is nonzero
        n_hi   = ((64'(r_it2.ticks) >> ssih_pkg::LIM_W) != 64'd0) && (i_cfg.bin_scale != '0);
        n_prod = ssih_pkg::t_prod'(ssih_pkg::t_mlo'(r_it2.ticks))
               * ssih_pkg::t_prod'(i_cfg.bin_scale);

        sum = ssih_pkg::t_sum'(r_prod) + ssih_pkg::t_sum'(i_cfg.bin_offset);
        ovf = r_hi || (sum >= ssih_pkg::BIN_LIMIT);
        bin = ovf ? ssih_pkg::t_bin'(ssih_pkg::NUM_BINS)
                  : ssih_pkg::t_bin'(sum >> ssih_pkg::FRAC_BITS);
        oob = (int'(r_it3.ridx) > ssih_pkg::NUM_BINS);

        o_req.op    = r_it3.op;
        o_req.close = r_it3.close;
        o_req.ticks = r_it3.ticks;
        o_req.oob   = oob;
        if (r_it3.op == ssih_pkg::OP_READ) begin
            o_req.addr = oob ? '0 : ssih_pkg::t_bin'(r_it3.ridx);
        end else begin
            o_req.addr = bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_it2 <= i_item;
        end
        if (rdy3 && r_v2) begin
            r_it3  <= r_it2;
            r_prod <= n_prod;
            r_hi   <= n_hi;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ssih_bank.sv =====
`default_nettype none
`include "start_stop_interval_histogram_assert.svh"
module ssih_bank (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  ssih_pkg::t_bin_req i_req,
    output logic               o_valid,
    input  wire                i_ready,
    output ssih_pkg::t_result  o_res
);

    ssih_pkg::t_cnt            r_mem [ssih_pkg::DEPTH];
    logic [ssih_pkg::DEPTH-1:0] r_vld;

    logic               r_vw;
    ssih_pkg::t_bin_req r_reqw;
    ssih_pkg::t_cnt     r_rdata;
    logic               r_rvld;
    logic               r_fhit;
    ssih_pkg::t_cnt     r_fdata;
    logic               r_vo;
    ssih_pkg::t_result  r_res;

    logic              rdy_w;
    logic              rdy_o;
    logic              load;
    logic              wr_en;
    ssih_pkg::t_bin    wr_addr;
    ssih_pkg::t_cnt    wr_data;
    ssih_pkg::t_cnt    cur;
    ssih_pkg::t_result n_res;

    always_comb begin
        rdy_o   = !r_vo || i_ready;
        rdy_w   = !r_vw || rdy_o;
        o_ready = rdy_w;
        load    = rdy_w && i_valid;

        // forwarded value covers a write on the same edge as the read
        cur = r_fhit ? r_fdata : (r_rvld ? r_rdata : '0);
        wr_en   = r_vw && rdy_o && r_reqw.close;
        wr_addr = r_reqw.addr;
        wr_data = (cur == ssih_pkg::CNT_MAX) ? cur : cur + 1'b1;

        n_res.ivl_valid = r_reqw.close;
        n_res.ticks     = r_reqw.close ? ssih_pkg::t_ts'(r_reqw.ticks) : '0;
        n_res.bin       = r_reqw.close ? ssih_pkg::t_obin'(r_reqw.addr) : '0;
        n_res.count     = ((r_reqw.op == ssih_pkg::OP_READ) && !r_reqw.oob) ? cur : '0;

        o_valid = r_vo;
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (load) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_reqw  <= i_req;
            r_rvld  <= r_vld[i_req.addr];
            r_fhit  <= wr_en && (wr_addr == i_req.addr);
            r_fdata <= wr_data;
        end
        if (rdy_o && r_vw) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_w) begin
                r_vw <= i_valid;
            end
            if (rdy_o) begin
                r_vo <= r_vw;
            end
        end
    end

    `SSIH_ASSERT_NXT(a_wr_sets_vld, i_clk, i_rst_n, wr_en, r_vld[$past(wr_addr)], "bin not marked written")
    `SSIH_ASSERT_IMP(a_cnt_no_wrap, i_clk, i_rst_n, wr_en, wr_data != '0, "bin count wrapped")

endmodule
`default_nettype wire

// ===== rtl/core/start_stop_interval_histogram.sv =====
`default_nettype none
`include "start_stop_interval_histogram_assert.svh"
// Start/stop interval histogram. Each input transaction is either a timestamped channel event
// or a bin read, and yields exactly one output transaction, in order. A start-channel event arms
// the block and latches its timestamp; a stop-channel event while armed whose tick difference
// exceeds min_gap closes an interval, reports ticks and bin, and bumps that bin's saturating
// 32-bit count (bin NUM_BINS is overflow). The block takes one transaction per clock sustained
// while i_m_tready holds. Results pass through a five-register pipeline: input/arm stage (arm
// and start-time update), multiply, bin add and compare with count-bank read, count
// read-modify-write with one-deep write forwarding, and the output register. The histogram reads
// as zero after reset through per-bin written flags, so no clearing pass is needed. Configuration
// writes are taken in any cycle but belong to idle time.
module start_stop_interval_histogram (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // timestamp[47:0], read_index[54:48], zero pad[55]
    input  wire [ssih_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // op[0], channel[2:1]
    input  wire [ssih_pkg::IN_TUSER_W-1:0]       i_s_tuser,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // interval_ticks[47:0], interval_bin[54:48], bin_count[86:55], zero pad[87]
    output logic [ssih_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // interval_valid[0]
    output logic [ssih_pkg::OUT_TUSER_W-1:0]     o_m_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [ssih_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [ssih_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    ssih_pkg::t_cfg      r_cfg;
    logic                ivl_valid;
    logic                ivl_ready;
    ssih_pkg::t_ivl_item ivl_item;
    logic                req_valid;
    logic                req_ready;
    ssih_pkg::t_bin_req  req;
    ssih_pkg::t_result   res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap    <= ssih_pkg::MIN_GAP_RST;
            r_cfg.bin_scale  <= ssih_pkg::BIN_SCALE_RST;
            r_cfg.bin_offset <= ssih_pkg::BIN_OFFSET_RST;
            r_cfg.start_ch   <= ssih_pkg::START_CH_RST;
            r_cfg.stop_ch    <= ssih_pkg::STOP_CH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssih_pkg::CFG_MIN_GAP:    r_cfg.min_gap    <= i_cfg_data[ssih_pkg::GAP_W-1:0];
                ssih_pkg::CFG_BIN_SCALE:  r_cfg.bin_scale  <= i_cfg_data[ssih_pkg::SCALE_W-1:0];
                ssih_pkg::CFG_BIN_OFFSET: r_cfg.bin_offset <= i_cfg_data[ssih_pkg::OFFS_W-1:0];
                ssih_pkg::CFG_START_CH:   r_cfg.start_ch   <= i_cfg_data[ssih_pkg::CH_W-1:0];
                ssih_pkg::CFG_STOP_CH:    r_cfg.stop_ch    <= i_cfg_data[ssih_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssih_interval u_interval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser[0]),
        .i_ch    (i_s_tuser[2:1]),
        .i_ts    (i_s_tdata[47:0]),
        .i_ridx  (i_s_tdata[54:48]),
        .o_valid (ivl_valid),
        .i_ready (ivl_ready),
        .o_item  (ivl_item)
    );

    ssih_binner u_binner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (ivl_valid),
        .o_ready (ivl_ready),
        .i_item  (ivl_item),
        .o_valid (req_valid),
        .i_ready (req_ready),
        .o_req   (req)
    );

    ssih_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {1'b0, res.count, res.bin, res.ticks};
    assign o_m_tuser = res.ivl_valid;

    `SSIH_ASSERT_IMP(a_stall_needs_out, i_clk, i_rst_n, !o_s_tready, o_m_tvalid, "stall with empty output")

endmodule
`default_nettype wire
